/* hdl/jst_pkg.sv */
// ----------------------------------------------------------------------------
// JSON subset tokenizer package
// Token kinds, error codes and the token and token-pair types shared by the
// scanner core, the result queue and the top level.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_COLON  = 4'd2;
    localparam logic [3:0] KIND_COMMA  = 4'd3;
    localparam logic [3:0] KIND_NUMBER = 4'd4;
    localparam logic [3:0] KIND_STRING = 4'd5;
    localparam logic [3:0] KIND_KEY    = 4'd6;
    localparam logic [3:0] KIND_TRUE   = 4'd7;
    localparam logic [3:0] KIND_EOF    = 4'd10;
    localparam logic [3:0] KIND_ERROR  = 4'd11;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ERR_SECOND_DOT = 3'd2;
    localparam logic [2:0] ERR_BAD_WORD   = 3'd3;
    localparam logic [2:0] ERR_OPEN_STR   = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd5;

    // Depth of the result queue, counted in token pairs.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [2:0]  err;
        logic        last;
    } t_tok;

    // One input item gives at most two tokens; they travel together.
    typedef struct packed {
        logic two;
        t_tok first;
        t_tok second;
    } t_pair;

endpackage

/* hdl/jst_core.sv */
// ----------------------------------------------------------------------------
// JSON subset tokenizer scanner core
// Registers the incoming byte, then advances the scan state and forms the
// token pair caused by that byte from the registered copy.
// ----------------------------------------------------------------------------
module jst_core import jst_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [7:0]               i_byte,
    input  logic                     i_marker,
    output logic                     o_ready,
    input  logic [QUEUE_AW:0]        i_level,
    output logic                     o_push,
    output t_pair                    o_pair
);

    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_INT     = 3'd1;
    localparam logic [2:0] PH_FRAC    = 3'd2;
    localparam logic [2:0] PH_STRING  = 3'd3;
    localparam logic [2:0] PH_WORD    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_LBR   = 8'h7b;
    localparam logic [7:0] CH_RBR   = 8'h7d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    function automatic logic [7:0] word_char(input logic [1:0] c, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (c)
            2'd0: begin
                case (idx)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return b == "t" || b == "r" || b == "e" || b == "f" || b == "a" ||
               b == "s" || b == "n" || b == "u" || b == "l";
    endfunction

    logic                     r_in_vld;
    logic [7:0]               r_in_byte;
    logic                     r_in_mark;

    logic [2:0]               r_phase, n_phase;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_cs, n_cs;
    logic [1:0]               r_choice, n_choice;
    logic [2:0]               r_prog, n_prog;
    logic                     r_hv, n_hv;
    logic [15:0]              r_hs, n_hs;
    logic [15:0]              r_hl, n_hl;

    logic                     w_ending, w_digit, w_letter;
    logic [1:0]               w_c;
    logic [2:0]               w_len;
    logic [POSITION_BITS-1:0] w_pos_inc;
    logic                     pre_v, main_v;
    t_tok                     pre_t, main_t;
    logic                     do_between, do_err, err_end, do_clear, f_req;
    logic [2:0]               err_code;
    logic [3:0]               f_kind;

    // Room for the pair of the item in flight and the next one is reserved.
    assign o_ready = ({1'b0, i_level} + {{(QUEUE_AW + 1){1'b0}}, r_in_vld})
                     <= (QUEUE_AW + 2)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_valid && o_ready;
        end
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_mark <= i_marker;
        end
    end

    assign w_ending  = r_in_mark || (r_in_byte == 8'h00);
    assign w_digit   = (r_in_byte >= CH_0) && (r_in_byte <= CH_9);
    assign w_letter  = is_letter(r_in_byte);
    assign w_c       = (r_choice == 2'd3) ? 2'd2 : r_choice;
    assign w_len     = (w_c == 2'd1) ? 3'd5 : 3'd4;
    assign w_pos_inc = r_pos + POSITION_BITS'(1);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_cs       = r_cs;
        n_choice   = r_choice;
        n_prog     = r_prog;
        n_hv       = r_hv;
        n_hs       = r_hs;
        n_hl       = r_hl;
        pre_v      = 1'b0;
        main_v     = 1'b0;
        pre_t      = '0;
        main_t     = '0;
        do_between = 1'b0;
        do_err     = 1'b0;
        err_end    = 1'b0;
        err_code   = ERR_NONE;
        do_clear   = 1'b0;
        f_req      = 1'b0;
        f_kind     = KIND_STRING;

        if (r_in_vld) begin
            if (r_phase == PH_ERROR) begin
                do_clear = r_in_mark;
            end else if (!w_ending && r_pos == POS_MAX) begin
                do_err   = 1'b1;
                err_code = ERR_TOO_LONG;
            end else begin
                case (r_phase)
                    PH_INT, PH_FRAC: begin
                        if (!w_ending && w_digit) begin
                            n_pos = w_pos_inc;
                        end else if (!w_ending && r_in_byte == CH_DOT) begin
                            if (r_phase == PH_FRAC) begin
                                do_err   = 1'b1;
                                err_code = ERR_SECOND_DOT;
                            end else begin
                                n_phase = PH_FRAC;
                                n_pos   = w_pos_inc;
                            end
                        end else begin
                            pre_v        = 1'b1;
                            pre_t.kind   = KIND_NUMBER;
                            pre_t.start  = 16'(r_cs);
                            pre_t.length = 16'(r_pos - r_cs);
                            do_between   = 1'b1;
                        end
                    end
                    PH_STRING: begin
                        if (w_ending) begin
                            do_err   = 1'b1;
                            err_code = ERR_OPEN_STR;
                            err_end  = 1'b1;
                        end else begin
                            if (r_in_byte == CH_QUOTE) begin
                                n_hv    = 1'b1;
                                n_hs    = 16'(r_cs);
                                n_hl    = 16'(r_pos - r_cs);
                                n_phase = PH_BETWEEN;
                            end
                            n_pos = w_pos_inc;
                        end
                    end
                    PH_WORD: begin
                        if (!w_ending && w_letter) begin
                            if (r_prog < w_len && r_in_byte == word_char(w_c, r_prog)) begin
                                n_prog = r_prog + 3'd1;
                                n_pos  = w_pos_inc;
                            end else begin
                                do_err   = 1'b1;
                                err_code = ERR_BAD_WORD;
                            end
                        end else if (r_prog != w_len) begin
                            do_err   = 1'b1;
                            err_code = ERR_BAD_WORD;
                            err_end  = w_ending;
                        end else begin
                            pre_v        = 1'b1;
                            pre_t.kind   = KIND_TRUE + {2'b00, w_c};
                            pre_t.start  = 16'(r_cs);
                            pre_t.length = 16'(w_len);
                            do_between   = 1'b1;
                        end
                    end
                    default: begin
                        do_between = 1'b1;
                    end
                endcase
            end

            if (do_between) begin
                n_phase = PH_BETWEEN;
                if (w_ending) begin
                    f_req        = 1'b1;
                    main_v       = 1'b1;
                    main_t.kind  = KIND_EOF;
                    main_t.start = 16'(r_pos);
                    main_t.last  = 1'b1;
                    do_clear     = 1'b1;
                end else begin
                    case (r_in_byte)
                        CH_SPACE, CH_NL: begin
                            n_pos = w_pos_inc;
                        end
                        CH_COLON: begin
                            f_req         = 1'b1;
                            f_kind        = KIND_KEY;
                            main_v        = 1'b1;
                            main_t.kind   = KIND_COLON;
                            main_t.start  = 16'(r_pos);
                            main_t.length = 16'd1;
                            n_pos         = w_pos_inc;
                        end
                        CH_LBR, CH_RBR, CH_COMMA: begin
                            f_req         = 1'b1;
                            main_v        = 1'b1;
                            main_t.kind   = (r_in_byte == CH_LBR) ? KIND_LBRACE :
                                            (r_in_byte == CH_RBR) ? KIND_RBRACE : KIND_COMMA;
                            main_t.start  = 16'(r_pos);
                            main_t.length = 16'd1;
                            n_pos         = w_pos_inc;
                        end
                        CH_T, CH_F, CH_N: begin
                            f_req    = 1'b1;
                            n_choice = (r_in_byte == CH_T) ? 2'd0 :
                                       (r_in_byte == CH_F) ? 2'd1 : 2'd2;
                            n_prog   = 3'd1;
                            n_cs     = r_pos;
                            n_phase  = PH_WORD;
                            n_pos    = w_pos_inc;
                        end
                        CH_QUOTE: begin
                            f_req   = 1'b1;
                            n_cs    = w_pos_inc;
                            n_phase = PH_STRING;
                            n_pos   = w_pos_inc;
                        end
                        default: begin
                            if (w_digit) begin
                                f_req   = 1'b1;
                                n_cs    = r_pos;
                                n_phase = PH_INT;
                                n_pos   = w_pos_inc;
                            end else begin
                                do_err   = 1'b1;
                                err_code = ERR_BAD_CHAR;
                            end
                        end
                    endcase
                end
            end

            if (do_err) begin
                f_req        = 1'b1;
                f_kind       = KIND_STRING;
                main_v       = 1'b1;
                main_t.kind  = KIND_ERROR;
                main_t.start = 16'(r_pos);
                main_t.err   = err_code;
                main_t.last  = 1'b1;
                if (err_end) begin
                    do_clear = 1'b1;
                end else begin
                    n_phase = PH_ERROR;
                end
            end

            // A held string is released ahead of whatever token comes next.
            if (f_req && r_hv) begin
                pre_v        = 1'b1;
                pre_t        = '0;
                pre_t.kind   = f_kind;
                pre_t.start  = r_hs;
                pre_t.length = r_hl;
                n_hv         = 1'b0;
            end

            if (do_clear) begin
                n_phase  = PH_BETWEEN;
                n_pos    = '0;
                n_cs     = '0;
                n_choice = 2'd0;
                n_prog   = 3'd0;
                n_hv     = 1'b0;
                n_hs     = 16'd0;
                n_hl     = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BETWEEN;
            r_pos    <= '0;
            r_cs     <= '0;
            r_choice <= 2'd0;
            r_prog   <= 3'd0;
            r_hv     <= 1'b0;
            r_hs     <= 16'd0;
            r_hl     <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_cs     <= n_cs;
            r_choice <= n_choice;
            r_prog   <= n_prog;
            r_hv     <= n_hv;
            r_hs     <= n_hs;
            r_hl     <= n_hl;
        end
    end

    assign o_push        = pre_v || main_v;
    assign o_pair.two    = pre_v && main_v;
    assign o_pair.first  = pre_v ? pre_t : main_t;
    assign o_pair.second = main_t;

endmodule

/* hdl/jst_queue.sv */
// ----------------------------------------------------------------------------
// JSON subset tokenizer result queue
// Stores token pairs and hands them out one token per item on the output
// stream.
// ----------------------------------------------------------------------------
module jst_queue import jst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_pair             i_pair,
    output logic [QUEUE_AW:0] o_level,
    output logic              o_valid,
    input  logic              i_ready,
    output t_tok              o_tok
);

    t_pair               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                r_sub;
    t_pair               w_head;
    logic                w_take, w_pop;

    assign w_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_sub ? w_head.second : w_head.first;
    assign o_level = r_cnt;
    assign w_take  = o_valid && i_ready;
    // A pair leaves once its last token is taken.
    assign w_pop   = w_take && (r_sub || !w_head.two);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd  <= r_rd + QUEUE_AW'(1);
                r_sub <= 1'b0;
            end else if (w_take) begin
                r_sub <= 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW + 1)'(i_push) - (QUEUE_AW + 1)'(w_pop);
        end
    end

endmodule

/* hdl/json_subset_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// JSON subset tokenizer
// Splits a byte stream of a small JSON subset into tokens with kind, offset
// and length.
// ----------------------------------------------------------------------------
// Input stream: one text byte per item in s_axis_tdata; s_axis_tlast marks the
// end of the text, and a zero byte ends it as well.
// Output stream: one token per item; m_axis_tlast is set on the end-of-text or
// error token that closes a text.
// An input byte is registered, then scanned in the next cycle, and its tokens
// are written to a four-pair result queue; the first token of a byte reaches
// the output through the input register and then the queue.
// The block takes one byte per cycle while s_axis_tready is high. A byte may
// cause two tokens (a released string or a finished number or keyword,
// followed by the token of the byte itself), which leave one after the other;
// a long run of such bytes is then held back by the output stream.
// When the receiver stalls, the queue fills and s_axis_tready drops once it
// holds two pairs with a byte in flight.
// Reset clears the scan state, so the next byte starts a text at offset zero,
// and empties the queue.
// ----------------------------------------------------------------------------
module json_subset_tokenizer_top import jst_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // end_marker
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
                                        // [35:20] token_length, [38:36] error_code
    output logic        m_axis_tlast    // last_of_text
);

    logic              w_push;
    t_pair             w_pair;
    logic [QUEUE_AW:0] w_level;
    t_tok              w_tok;

    jst_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_marker (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_level  (w_level),
        .o_push   (w_push),
        .o_pair   (w_pair)
    );

    jst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pair  (w_pair),
        .o_level (w_level),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (w_tok)
    );

    assign m_axis_tdata = {1'b0, w_tok.err, w_tok.length, w_tok.start, w_tok.kind};
    assign m_axis_tlast = w_tok.last;

    // The queue never overflows.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_level == (QUEUE_AW + 1)'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    // After a push, the output stream presents a token in the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> m_axis_tvalid)
        else $error("pushed tokens not presented");

    // Only an end-of-text or error token closes a text.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (w_tok.kind == KIND_EOF || w_tok.kind == KIND_ERROR))
        else $error("last flag on an ordinary token");

endmodule
